// ----- rtl/core/modexp_pkg.sv -----
// Shared word size, types and register indexes for the modular exponentiation block.
package modexp_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_BITS = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS          = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRIVATE_EXPONENT = 1'b1;

endpackage

// ----- rtl/core/modular_exponentiation_top.sv -----
// Diffie-Hellman modular exponentiation: base to the private exponent modulo the modulus.
//
// Each accepted base yields one result, base ^ private_exponent mod modulus, computed by
// square-and-multiply over all WORD_BITS exponent bits, most significant first. Every
// modular multiply is a bit-serial shift-and-add that takes one multiplier bit per cycle.
// A transaction is accepted, the base is reduced by restoring division, then one squaring
// runs per exponent bit and one further multiply per set exponent bit, and the result is
// handed to the output register once it is free. A zero modulus gives a zero result
// without the reduction or the multiplies. One transaction is in flight at a time;
// a finished result waits in the output register while the next base is accepted.
// Configuration must be written only while the block is idle; the block itself does
// not enforce it.
module modular_exponentiation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  modexp_pkg::word_type                req_base_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output modexp_pkg::word_type                rsp_power_result,
   input  logic                                csr_write_enable,
   input  logic [modexp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  modexp_pkg::word_type                csr_write_data
);
   import modexp_pkg::*;

   localparam int EXT_BITS = WORD_BITS + 2;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_MUL    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   word_type   modulus_ff, modulus_in;
   word_type   exponent_ff, exponent_in;
   word_type   dividend_ff, dividend_in;
   word_type   base_ff, base_in;
   word_type   prod_ff, prod_in;
   word_type   mcand_ff, mcand_in;
   word_type   mplier_ff, mplier_in;
   word_type   exp_ff, exp_in;
   word_type   result_ff, result_in;
   word_type   rsp_data_ff, rsp_data_in;
   count_type  bit_cnt_ff, bit_cnt_in;
   count_type  exp_cnt_ff, exp_cnt_in;
   logic       square_ff, square_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Restoring division step for the base reduction.
   logic [WORD_BITS:0] rem_shift;
   word_type           rem_next;

   // One shift-and-add step of the modular multiply: (2 * prod + bit * mcand) mod m.
   logic [EXT_BITS-1:0] mod_ext, mod2_ext, step_sum;
   word_type            step_next;

   word_type acc_init;
   logic     out_free;

   always_comb begin
      rem_shift = {base_ff, dividend_ff[WORD_BITS-1]};
      if (rem_shift >= {1'b0, modulus_ff}) begin
         rem_next = WORD_BITS'(rem_shift - {1'b0, modulus_ff});
      end else begin
         rem_next = rem_shift[WORD_BITS-1:0];
      end
   end

   always_comb begin
      mod_ext  = {2'b00, modulus_ff};
      mod2_ext = {1'b0, modulus_ff, 1'b0};
      step_sum = {1'b0, prod_ff, 1'b0}
               + (mplier_ff[WORD_BITS-1] ? {2'b00, mcand_ff} : EXT_BITS'(0));
      priority if (step_sum >= mod2_ext) begin
         step_next = WORD_BITS'(step_sum - mod2_ext);
      end else if (step_sum >= mod_ext) begin
         step_next = WORD_BITS'(step_sum - mod_ext);
      end else begin
         step_next = step_sum[WORD_BITS-1:0];
      end
   end

   // One modulo a unit modulus is zero; otherwise it is one.
   assign acc_init = (modulus_ff == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      exponent_in  = exponent_ff;
      dividend_in  = dividend_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      exp_in       = exp_ff;
      result_in    = result_ff;
      rsp_data_in  = rsp_data_ff;
      bit_cnt_in   = bit_cnt_ff;
      exp_cnt_in   = exp_cnt_ff;
      square_in    = square_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODULUS:          modulus_in  = csr_write_data;
            CSR_PRIVATE_EXPONENT: exponent_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (modulus_ff == '0) begin
                  result_in = '0;
                  state_in  = ST_FINISH;
               end else begin
                  dividend_in = req_base_value;
                  base_in     = '0;
                  bit_cnt_in  = CNT_BITS'(WORD_BITS - 1);
                  state_in    = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            // base_ff serves as the running remainder until the reduction ends.
            base_in     = rem_next;
            dividend_in = {dividend_ff[WORD_BITS-2:0], 1'b0};
            bit_cnt_in  = bit_cnt_ff - CNT_BITS'(1);
            if (bit_cnt_ff == '0) begin
               exp_in     = exponent_ff;
               exp_cnt_in = CNT_BITS'(WORD_BITS - 1);
               prod_in    = '0;
               mcand_in   = acc_init;
               mplier_in  = acc_init;
               square_in  = 1'b1;
               bit_cnt_in = CNT_BITS'(WORD_BITS - 1);
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in    = step_next;
            mplier_in  = {mplier_ff[WORD_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - CNT_BITS'(1);
            if (bit_cnt_ff == '0) begin
               prod_in    = '0;
               bit_cnt_in = CNT_BITS'(WORD_BITS - 1);
               priority if (square_ff && exp_ff[WORD_BITS-1]) begin
                  mcand_in  = base_ff;
                  mplier_in = step_next;
                  square_in = 1'b0;
               end else if (exp_cnt_ff == '0) begin
                  result_in = step_next;
                  state_in  = ST_FINISH;
               end else begin
                  exp_in     = {exp_ff[WORD_BITS-2:0], 1'b0};
                  exp_cnt_in = exp_cnt_ff - CNT_BITS'(1);
                  mcand_in   = step_next;
                  mplier_in  = step_next;
                  square_in  = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in  = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= WORD_BITS'(2);
         exponent_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      exp_ff      <= exp_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
      bit_cnt_ff  <= bit_cnt_in;
      exp_cnt_ff  <= exp_cnt_in;
      square_ff   <= square_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

endmodule
